>>> src/cpp_pkg.sv
package cpp_pkg;

	localparam int CURSOR_ARRAY = 64;
	localparam int CURSOR_IMAGE = 16;
	localparam int CUR_PRESET = CURSOR_ARRAY - CURSOR_IMAGE;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 27;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH   = 3'd0,
		CFG_DEPTH_CODE     = 3'd1,
		CFG_VISIBLE_WIDTH  = 3'd2,
		CFG_VISIBLE_HEIGHT = 3'd3,
		CFG_HOTSPOT_X      = 3'd4,
		CFG_HOTSPOT_Y      = 3'd5,
		CFG_CURSOR_BASE    = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		DEPTH_1  = 3'd0,
		DEPTH_2  = 3'd1,
		DEPTH_4  = 3'd2,
		DEPTH_8  = 3'd3,
		DEPTH_16 = 3'd4,
		DEPTH_24 = 3'd5,
		DEPTH_32 = 3'd6
	} depth_t;

	// log2 of the horizontal pan step in pixels
	function automatic logic [2:0] step_shift(input logic [2:0] code);
		logic [2:0] k;
		case (depth_t'(code))
			DEPTH_1:  k = 3'd6;
			DEPTH_2:  k = 3'd5;
			DEPTH_4:  k = 3'd4;
			DEPTH_8:  k = 3'd3;
			DEPTH_16: k = 3'd2;
			DEPTH_24: k = 3'd3;
			DEPTH_32: k = 3'd1;
			default:  k = 3'd1;
		endcase
		return k;
	endfunction

endpackage

>>> src/cpp_point_if.sv
interface cpp_point_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] point_x;
	logic signed [14:0] point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

>>> src/cpp_result_if.sv
interface cpp_result_if;
	logic        valid;
	logic        ready;
	logic        pan_changed;
	logic [31:0] display_start_word;
	logic [31:0] cursor_preset_word;
	logic [31:0] cursor_offset_word;
	logic [31:0] cursor_position_word;

	modport source (output valid, output pan_changed, output display_start_word,
		output cursor_preset_word, output cursor_offset_word,
		output cursor_position_word, input ready);
	modport sink (input valid, input pan_changed, input display_start_word,
		input cursor_preset_word, input cursor_offset_word,
		input cursor_position_word, output ready);
endinterface

>>> src/cpp_cfg_if.sv
interface cpp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cpp_pkg::CFG_IDX_W-1:0]  index;
	logic [cpp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/cursor_pan_and_position_unit.sv
// each word is registered in s1, s2 and s3; throughput: one word per cycle
// while result.ready holds; the pan window registers update as a word
// leaves the input register, so the following word sees the moved window
// reset (arst_n low): pipeline empty, window 0..640 by 0..480, registers at
// their defaults (640 wide, 8 bits per pixel, hot point 0, cursor base 0)
module cursor_pan_and_position_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	cpp_point_if.sink    point,
	cpp_cfg_if.sink      cfg,
	cpp_result_if.source result
);

	localparam int XW = ((COORD_BITS > 15) ? COORD_BITS : 15) + 3;
	localparam int PW = COORD_BITS + 16;

	// configuration
	logic [13:0]        sw_q;
	logic [2:0]         dep_q;
	logic signed [6:0]  hsx_q;
	logic signed [6:0]  hsy_q;
	logic [26:0]        base_q;

	// pan window
	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

	// pipeline
	logic               v_s1, v_s2, v_s3;
	logic signed [14:0] px_s1, py_s1;
	logic               mv_s2;
	logic signed [COORD_BITS-1:0] mnx_s2, mny_s2;
	logic [31:0]        pre_s2, off_s2, pos_s2;
	logic               mv_s3;
	logic [31:0]        start_s3, pre_s3, off_s3, pos_s3;

	logic rdy1, rdy2, rdy3, fire_in, adv1, adv2, cfg_fire;

	assign rdy3 = !v_s3 || result.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign point.ready = rdy1;
	assign cfg.ready = 1'b1;
	assign fire_in = point.valid && rdy1;
	assign adv1 = v_s1 && rdy2;
	assign adv2 = v_s2 && rdy3;
	assign cfg_fire = cfg.valid && cfg.ready;

	// window move
	logic [2:0]         k;
	logic [5:0]         sm1;
	logic signed [XW-1:0] px_e, py_e, mnx_e, mny_e, mxx_e, mxy_e, fl_x, cl_x;
	logic               in_win, lo_y, hi_y, lo_x, hi_x;
	logic signed [COORD_BITS-1:0] mny_a, mxy_a, mny_b, mxy_b;
	logic signed [COORD_BITS-1:0] mnx_a, mxx_a, mnx_b, mxx_b;

	assign k = cpp_pkg::step_shift(dep_q);
	assign sm1 = 6'((7'd1 << k) - 7'd1);
	assign px_e = XW'(px_s1);
	assign py_e = XW'(py_s1);
	assign mnx_e = XW'(min_x_q);
	assign mny_e = XW'(min_y_q);
	assign mxx_e = XW'(max_x_q);
	assign mxy_e = XW'(max_y_q);
	assign fl_x = px_e & ~XW'(sm1);
	assign cl_x = (px_e + XW'(sm1)) & ~XW'(sm1);

	assign in_win = px_e >= mnx_e && px_e <= mxx_e && py_e >= mny_e && py_e <= mxy_e;

	// vertical first, each correction sees the one before it
	assign lo_y = py_e < mny_e;
	assign mny_a = lo_y ? COORD_BITS'(py_e) : min_y_q;
	assign mxy_a = lo_y ? COORD_BITS'(mxy_e - mny_e + py_e) : max_y_q;
	assign hi_y = py_e > XW'(mxy_a);
	assign mny_b = hi_y ? COORD_BITS'(XW'(mny_a) + py_e - XW'(mxy_a)) : mny_a;
	assign mxy_b = hi_y ? COORD_BITS'(py_e) : mxy_a;

	assign lo_x = px_e < mnx_e;
	assign mnx_a = lo_x ? COORD_BITS'(fl_x) : min_x_q;
	assign mxx_a = lo_x ? COORD_BITS'(mxx_e - mnx_e + fl_x) : max_x_q;
	assign hi_x = px_e > XW'(mxx_a);
	assign mnx_b = hi_x ? COORD_BITS'(XW'(mnx_a) + cl_x - XW'(mxx_a)) : mnx_a;
	assign mxx_b = hi_x ? COORD_BITS'(cl_x) : mxx_a;

	// cursor words
	logic signed [XW-1:0] cx, cy, xo, yo, xc, yc, prx, pry, yo2;
	logic [31:0]        pre_w, off_w, pos_w;

	assign cx = px_e - XW'(mnx_b) + XW'(hsx_q);
	assign cy = py_e - XW'(mny_b) + XW'(hsy_q);
	assign xo = cx[XW-1] ? cx : '0;
	assign yo = cy[XW-1] ? cy : '0;
	assign xc = cx[XW-1] ? '0 : cx;
	assign yc = cy[XW-1] ? '0 : cy;
	assign prx = XW'(cpp_pkg::CUR_PRESET) - xo;
	assign pry = XW'(cpp_pkg::CUR_PRESET) - yo;
	assign yo2 = -(yo <<< 1);
	assign pre_w = {pry[15:0], 16'h0000} | 32'(prx);
	assign off_w = 32'(base_q >> 3) + 32'(yo2);
	assign pos_w = {yc[15:0], 16'h0000} | 32'(xc);

	// display start
	logic signed [PW-1:0] lin, lin_r, quo;
	logic [31:0]        start_w;

	assign lin = PW'(mny_s2) * PW'($signed({1'b0, sw_q})) + PW'(mnx_s2);
	assign lin_r = lin[PW-1] ? lin + PW'(sm1) : lin;
	assign quo = lin_r >>> k;
	assign start_w = mv_s2 ? ({sw_q[12:3], 22'h000000} | 32'(quo)) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q <= 14'd640;
			dep_q <= 3'(cpp_pkg::DEPTH_8);
			hsx_q <= '0;
			hsy_q <= '0;
			base_q <= '0;
			min_x_q <= '0;
			min_y_q <= '0;
			max_x_q <= COORD_BITS'(640);
			max_y_q <= COORD_BITS'(480);
		end else if (cfg_fire) begin
			case (cpp_pkg::cfg_idx_t'(cfg.index))
				cpp_pkg::CFG_SCREEN_WIDTH: sw_q <= cfg.data[13:0];
				cpp_pkg::CFG_DEPTH_CODE: dep_q <= cfg.data[2:0];
				cpp_pkg::CFG_VISIBLE_WIDTH: begin
					min_x_q <= '0;
					max_x_q <= COORD_BITS'({1'b0, cfg.data[13:0]});
				end
				cpp_pkg::CFG_VISIBLE_HEIGHT: begin
					min_y_q <= '0;
					max_y_q <= COORD_BITS'({1'b0, cfg.data[13:0]});
				end
				cpp_pkg::CFG_HOTSPOT_X: hsx_q <= cfg.data[6:0];
				cpp_pkg::CFG_HOTSPOT_Y: hsy_q <= cfg.data[6:0];
				cpp_pkg::CFG_CURSOR_BASE: base_q <= cfg.data[26:0];
				default: begin
				end
			endcase
		end else if (adv1) begin
			min_x_q <= mnx_b;
			max_x_q <= mxx_b;
			min_y_q <= mny_b;
			max_y_q <= mxy_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (fire_in)
				v_s1 <= 1'b1;
			else if (adv1)
				v_s1 <= 1'b0;
			if (adv1)
				v_s2 <= 1'b1;
			else if (adv2)
				v_s2 <= 1'b0;
			if (adv2)
				v_s3 <= 1'b1;
			else if (result.ready)
				v_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) begin
			px_s1 <= point.point_x;
			py_s1 <= point.point_y;
		end
		if (adv1) begin
			mv_s2 <= !in_win;
			mnx_s2 <= mnx_b;
			mny_s2 <= mny_b;
			pre_s2 <= pre_w;
			off_s2 <= off_w;
			pos_s2 <= pos_w;
		end
		if (adv2) begin
			mv_s3 <= mv_s2;
			start_s3 <= start_w;
			pre_s3 <= pre_s2;
			off_s3 <= off_s2;
			pos_s3 <= pos_s2;
		end
	end

	assign result.valid = v_s3;
	assign result.pan_changed = mv_s3;
	assign result.display_start_word = start_s3;
	assign result.cursor_preset_word = pre_s3;
	assign result.cursor_offset_word = off_s3;
	assign result.cursor_position_word = pos_s3;

	logic [COORD_BITS-1:0] span_x, span_y;
	assign span_x = COORD_BITS'(max_x_q - min_x_q);
	assign span_y = COORD_BITS'(max_y_q - min_y_q);

`ifndef ASSERT_OFF
	a_span_x_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && !cfg_fire) |=> span_x == $past(span_x))
		else $error("horizontal window size changed on a move");

	a_span_y_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && !cfg_fire) |=> span_y == $past(span_y))
		else $error("vertical window size changed on a move");

	a_width_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_fire && cfg.index == cpp_pkg::CFG_VISIBLE_WIDTH) |=> min_x_q == '0)
		else $error("window left bound not cleared by width write");

	a_no_move_start: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !mv_s3) |-> start_s3 == 32'h0)
		else $error("start word set without a window move");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

	localparam logic [2:0] DEPTH_UNUSED = 3'd7;
	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic signed [14:0] x;
		logic signed [14:0] y;
	} point_word_t;

	typedef struct packed {
		logic        pan_changed;
		logic [31:0] start_word;
		logic [31:0] preset_word;
		logic [31:0] offset_word;
		logic [31:0] position_word;
	} cursor_word_t;

	logic clk;
	logic arst_n;

	cpp_point_if  point_ch();
	cpp_cfg_if    cfg_ch();
	cpp_result_if result_ch();

	cursor_pan_and_position_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.point(point_ch),
		.cfg(cfg_ch),
		.result(result_ch)
	);

	point_word_t  pending_points[$];
	cursor_word_t expected_words[$];
	point_word_t  next_point;
	cursor_word_t got_word;
	cursor_word_t want_word;
	int           mismatch_count;
	int           tx_idle_pct;
	int           rx_idle_pct;
	int           walk_x;
	int           walk_y;

	// predictor copy of the registers and pan window
	logic [13:0]        scr_w;
	logic [2:0]         depth_code;
	logic signed [6:0]  hot_x;
	logic signed [6:0]  hot_y;
	logic [26:0]        cur_base;
	logic signed [15:0] win_min_x;
	logic signed [15:0] win_min_y;
	logic signed [15:0] win_max_x;
	logic signed [15:0] win_max_y;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 400000);
		$display("Test completed with failures");
		$finish;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_REPORTS)
			$display("ERROR @%0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	function automatic longint wrap_coord(input longint v);
		logic signed [15:0] t;
		t = v[15:0];
		return t;
	endfunction

	function automatic longint floor_to(input longint v, input longint s);
		return v - (((v % s) + s) % s);
	endfunction

	function automatic longint pan_step_pixels(input logic [2:0] code);
		case (code)
			cpp_pkg::DEPTH_1:  return 64;
			cpp_pkg::DEPTH_2:  return 32;
			cpp_pkg::DEPTH_4:  return 16;
			cpp_pkg::DEPTH_8:  return 8;
			cpp_pkg::DEPTH_16: return 4;
			cpp_pkg::DEPTH_24: return 8;
			default:           return 2;
		endcase
	endfunction

	task automatic apply_register(input cpp_pkg::cfg_idx_t idx, input logic [26:0] val);
		case (idx)
			cpp_pkg::CFG_SCREEN_WIDTH: scr_w = val[13:0];
			cpp_pkg::CFG_DEPTH_CODE: depth_code = val[2:0];
			cpp_pkg::CFG_VISIBLE_WIDTH: begin
				win_min_x = '0;
				win_max_x = {2'b00, val[13:0]};
			end
			cpp_pkg::CFG_VISIBLE_HEIGHT: begin
				win_min_y = '0;
				win_max_y = {2'b00, val[13:0]};
			end
			cpp_pkg::CFG_HOTSPOT_X: hot_x = val[6:0];
			cpp_pkg::CFG_HOTSPOT_Y: hot_y = val[6:0];
			cpp_pkg::CFG_CURSOR_BASE: cur_base = val[26:0];
			default: ;
		endcase
	endtask

	// moves the pan window and derives the cursor words for one pointer word
	task automatic predict_cursor(input logic signed [14:0] px_in,
		input logic signed [14:0] py_in);
		longint px, py, stp, d, mnx, mny, mxx, mxy, x, y, xo, yo, off, hx, hy;
		logic [31:0] pitch_bits, a, b;
		cursor_word_t w;
		px = px_in;
		py = py_in;
		hx = hot_x;
		hy = hot_y;
		stp = pan_step_pixels(depth_code);
		mnx = win_min_x;
		mny = win_min_y;
		mxx = win_max_x;
		mxy = win_max_y;
		w = '0;
		if (!(px >= mnx && px <= mxx && py >= mny && py <= mxy)) begin
			w.pan_changed = 1'b1;
			if (py < mny) begin
				d = mny - py;
				mny = wrap_coord(mny - d);
				mxy = wrap_coord(mxy - d);
			end
			if (py > mxy) begin
				d = py - mxy;
				mny = wrap_coord(mny + d);
				mxy = wrap_coord(mxy + d);
			end
			if (px < mnx) begin
				d = mnx - floor_to(px, stp);
				mnx = wrap_coord(mnx - d);
				mxx = wrap_coord(mxx - d);
			end
			if (px > mxx) begin
				d = floor_to(px + stp - 1, stp) - mxx;
				mnx = wrap_coord(mnx + d);
				mxx = wrap_coord(mxx + d);
			end
			off = (mny * longint'(scr_w) + mnx) / stp;
			pitch_bits = 32'(scr_w / 8);
			w.start_word = (pitch_bits << 22) | off[31:0];
		end
		win_min_x = mnx[15:0];
		win_min_y = mny[15:0];
		win_max_x = mxx[15:0];
		win_max_y = mxy[15:0];

		x = px - mnx + hx;
		y = py - mny + hy;
		xo = 0;
		yo = 0;
		if (x < 0) begin
			xo = x;
			x = 0;
		end
		if (y < 0) begin
			yo = y;
			y = 0;
		end
		a = 32'(cpp_pkg::CUR_PRESET - yo);
		b = 32'(cpp_pkg::CUR_PRESET - xo);
		w.preset_word = (a << 16) | b;
		off = longint'(cur_base / 8) - yo * 2;
		w.offset_word = off[31:0];
		a = y[31:0];
		b = x[31:0];
		w.position_word = (a << 16) | b;
		expected_words.push_back(w);
	endtask

	// pointer word driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (point_ch.valid && point_ch.ready)
				predict_cursor(point_ch.point_x, point_ch.point_y);
			if (!point_ch.valid || point_ch.ready) begin
				if (pending_points.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					next_point = pending_points.pop_front();
					point_ch.valid <= 1'b1;
					point_ch.point_x <= next_point.x;
					point_ch.point_y <= next_point.y;
				end else begin
					point_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result word monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got_word.pan_changed = result_ch.pan_changed;
				got_word.start_word = result_ch.display_start_word;
				got_word.preset_word = result_ch.cursor_preset_word;
				got_word.offset_word = result_ch.cursor_offset_word;
				got_word.position_word = result_ch.cursor_position_word;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected result word %h", got_word));
				end else begin
					want_word = expected_words.pop_front();
					if (got_word.pan_changed !== want_word.pan_changed)
						report_mismatch($sformatf("pan_changed got %b expected %b",
							got_word.pan_changed, want_word.pan_changed));
					if (got_word.start_word !== want_word.start_word)
						report_mismatch($sformatf("display_start_word got %h expected %h",
							got_word.start_word, want_word.start_word));
					if (got_word.preset_word !== want_word.preset_word)
						report_mismatch($sformatf("cursor_preset_word got %h expected %h",
							got_word.preset_word, want_word.preset_word));
					if (got_word.offset_word !== want_word.offset_word)
						report_mismatch($sformatf("cursor_offset_word got %h expected %h",
							got_word.offset_word, want_word.offset_word));
					if (got_word.position_word !== want_word.position_word)
						report_mismatch($sformatf("cursor_position_word got %h expected %h",
							got_word.position_word, want_word.position_word));
				end
			end
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic write_register(input cpp_pkg::cfg_idx_t idx, input logic [26:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		apply_register(idx, val);
	endtask

	task automatic configure(input int sw, input int dc, input int vw, input int vh,
		input int hx, input int hy, input int base);
		write_register(cpp_pkg::CFG_SCREEN_WIDTH, 27'(sw));
		write_register(cpp_pkg::CFG_DEPTH_CODE, 27'(dc));
		write_register(cpp_pkg::CFG_VISIBLE_WIDTH, 27'(vw));
		write_register(cpp_pkg::CFG_VISIBLE_HEIGHT, 27'(vh));
		write_register(cpp_pkg::CFG_HOTSPOT_X, 27'(hx));
		write_register(cpp_pkg::CFG_HOTSPOT_Y, 27'(hy));
		write_register(cpp_pkg::CFG_CURSOR_BASE, 27'(base));
	endtask

	task automatic configure_random(input int dc);
		configure($urandom_range(8192, 1), dc, $urandom_range(8192, 1),
			$urandom_range(8192, 1), $urandom_range(127, 0), $urandom_range(127, 0),
			$urandom_range(16777215, 0) * 8);
	endtask

	task automatic push_point(input int x, input int y);
		point_word_t p;
		p.x = x[14:0];
		p.y = y[14:0];
		pending_points.push_back(p);
		walk_x = x;
		walk_y = y;
	endtask

	// pointer walk: mostly small moves, some pauses and far jumps
	task automatic push_walk(input int count);
		int r, span, nx, ny;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			nx = walk_x;
			ny = walk_y;
			if (r < 8) begin
				nx = int'($urandom_range(32767, 0)) - 16384;
				ny = int'($urandom_range(32767, 0)) - 16384;
			end else if (r >= 16) begin
				span = (r < 50) ? 16 : (r < 85) ? 300 : 3000;
				nx += int'($urandom_range(2 * span, 0)) - span;
				ny += int'($urandom_range(2 * span, 0)) - span;
				if (nx > 16383) nx = 16383;
				if (nx < -16384) nx = -16384;
				if (ny > 16383) ny = 16383;
				if (ny < -16384) ny = -16384;
			end
			push_point(nx, ny);
		end
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0 || point_ch.valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
	endtask

	initial begin
		mismatch_count = 0;
		walk_x = 0;
		walk_y = 0;
		scr_w = 14'd640;
		depth_code = cpp_pkg::DEPTH_8;
		hot_x = '0;
		hot_y = '0;
		cur_base = '0;
		win_min_x = '0;
		win_min_y = '0;
		win_max_x = 16'sd640;
		win_max_y = 16'sd480;
		set_idling(38, 60);
		arst_n = 1'b0;
		point_ch.valid = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = cpp_pkg::CFG_SCREEN_WIDTH;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: corners, single steps past each edge, far extremes
		push_point(0, 0);
		push_point(640, 480);
		push_point(641, 480);
		push_point(641, 481);
		push_point(-1, 0);
		push_point(0, -1);
		push_point(-16384, -16384);
		push_point(16383, 16383);
		push_point(-16384, 16383);
		push_point(16383, -16384);
		push_point(0, 0);
		push_point(-5, -3);
		push_point(100, 100);
		push_walk(80);
		wait_drained();

		// 8192-wide screen, coarsest step, tiny window, hot point pulls cursor negative
		configure(8192, cpp_pkg::DEPTH_1, 1, 1, -64, -64, 0);
		push_point(0, 0);
		push_point(1, 1);
		push_point(2, 2);
		push_point(-1, -1);
		push_point(63, 0);
		push_point(16383, 16383);
		push_point(-16384, -16384);
		push_walk(95);
		wait_drained();

		configure(1, cpp_pkg::DEPTH_32, 8192, 8192, 63, 63, 134217720);
		push_walk(100);
		wait_drained();

		set_idling(60, 38);
		configure($urandom_range(8192, 1), DEPTH_UNUSED, $urandom_range(64, 1),
			$urandom_range(64, 1), -1, 5, 8);
		push_walk(100);
		wait_drained();

		configure(16383, cpp_pkg::DEPTH_24, 0, 16383, $urandom_range(127, 0),
			$urandom_range(127, 0), 27'h7ffffff);
		push_walk(100);
		wait_drained();

		set_idling(0, 0);
		configure_random($urandom_range(7, 0));
		push_walk(100);
		wait_drained();

		configure_random(cpp_pkg::DEPTH_16);
		push_walk(100);
		wait_drained();

		repeat (8) @(posedge clk);
		if (expected_words.size() != 0)
			report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> cursor_pan_and_position_unit.f
src/cpp_pkg.sv
src/cpp_point_if.sv
src/cpp_result_if.sv
src/cpp_cfg_if.sv
src/cursor_pan_and_position_unit.sv
tb/sv/tb_top.sv
